/* rtl/tsc_pkg.sv */
package tsc_pkg;

	localparam int CNT_W = 5;
	localparam int SQRT_STEPS = 30;
	localparam int ATAN_STEPS_MAX = 24;
	localparam int ANGLE_MAX = 23040;

	localparam logic [14:0] MOD_UP = 15'd12780;
	localparam logic [14:0] MOD_DOWN = 15'd18350;
	localparam logic [14:0] MOD_ONE = 15'd16384;

	localparam logic [1:0] SLOPE_LEVEL = 2'd0;
	localparam logic [1:0] SLOPE_UP = 2'd1;
	localparam logic [1:0] SLOPE_DOWN = 2'd2;

	localparam logic CMD_MEASURE = 1'b0;
	localparam logic CMD_CAL = 1'b1;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_UP_LIMIT = 2'd1;
	localparam logic [1:0] REG_DOWN_LIMIT = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_Z,
		ST_SQRT_INIT,
		ST_SQRT,
		ST_CORDIC_INIT,
		ST_CORDIC,
		ST_ANGLE,
		ST_DIV_INIT,
		ST_DIV,
		ST_FINISH
	} tsc_state_t;

	typedef struct packed {
		logic take;
		logic mul_x;
		logic mul_z;
		logic sqrt_init;
		logic sqrt_step;
		logic cordic_init;
		logic cordic_step;
		logic angle;
		logic div_init;
		logic div_step;
		logic commit;
	} tsc_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic sqrt_last;
		logic cordic_last;
		logic cal_last;
		logic out_free;
	} tsc_stat_t;

	// atan(2^-i) in degrees, Q16
	function automatic logic [21:0] atan_q16(input logic [CNT_W-1:0] i);
		logic [21:0] r;
		unique case (i)
			5'd0: r = 22'd2949120;
			5'd1: r = 22'd1740967;
			5'd2: r = 22'd919879;
			5'd3: r = 22'd466945;
			5'd4: r = 22'd234379;
			5'd5: r = 22'd117304;
			5'd6: r = 22'd58666;
			5'd7: r = 22'd29335;
			5'd8: r = 22'd14668;
			5'd9: r = 22'd7334;
			5'd10: r = 22'd3667;
			5'd11: r = 22'd1833;
			5'd12: r = 22'd917;
			5'd13: r = 22'd458;
			5'd14: r = 22'd229;
			5'd15: r = 22'd115;
			5'd16: r = 22'd57;
			5'd17: r = 22'd29;
			5'd18: r = 22'd14;
			5'd19: r = 22'd7;
			5'd20: r = 22'd4;
			5'd21: r = 22'd2;
			5'd22: r = 22'd1;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/tsc_if.sv */
interface tsc_in_if;
	logic valid;
	logic ready;
	logic cmd;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	modport source(output valid, cmd, accel_x, accel_y, accel_z, input ready);
	modport sink(input valid, cmd, accel_x, accel_y, accel_z, output ready);
endinterface

interface tsc_out_if;
	logic valid;
	logic ready;
	logic signed [16:0] pitch;
	logic [1:0] slope;
	logic [14:0] rate_modifier;
	logic cal_done;
	logic signed [15:0] offset_now;
	modport source(output valid, pitch, slope, rate_modifier, cal_done, offset_now,
		input ready);
	modport sink(input valid, pitch, slope, rate_modifier, cal_done, offset_now,
		output ready);
endinterface

interface tsc_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [14:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* rtl/tsc_ctrl.sv */
module tsc_ctrl
	import tsc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  tsc_stat_t stat,
	output tsc_cmd_t  cmd
);

	tsc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.take = 1'b1;
				if (stat.in_valid) state_d = ST_MUL_X;
			end
			ST_MUL_X: begin
				cmd.mul_x = 1'b1;
				state_d = ST_MUL_Z;
			end
			ST_MUL_Z: begin
				cmd.mul_z = 1'b1;
				state_d = ST_SQRT_INIT;
			end
			ST_SQRT_INIT: begin
				cmd.sqrt_init = 1'b1;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (stat.sqrt_last) state_d = ST_CORDIC_INIT;
			end
			ST_CORDIC_INIT: begin
				cmd.cordic_init = 1'b1;
				state_d = ST_CORDIC;
			end
			ST_CORDIC: begin
				cmd.cordic_step = 1'b1;
				if (stat.cordic_last) state_d = ST_ANGLE;
			end
			ST_ANGLE: begin
				cmd.angle = 1'b1;
				state_d = stat.cal_last ? ST_DIV_INIT : ST_FINISH;
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				// The result waits here until the output register is free.
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* rtl/tsc_dp.sv */
module tsc_dp
	import tsc_pkg::*;
#(
	parameter int CAL_SAMPLES = 10,
	parameter int CORDIC_STEPS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  tsc_cmd_t  cmd,
	output tsc_stat_t stat,
	tsc_in_if.sink    sample,
	tsc_cfg_if.sink   cfg,
	tsc_out_if.source result
);

	localparam int STEPS = (CORDIC_STEPS > ATAN_STEPS_MAX) ? ATAN_STEPS_MAX : CORDIC_STEPS;
	localparam int SUM_W = $clog2(CAL_SAMPLES * ANGLE_MAX + 1) + 1;
	localparam int NUM_W = SUM_W + 1;
	localparam int DEN = 2 * CAL_SAMPLES;
	localparam int CCNT_W = $clog2(CAL_SAMPLES + 1);
	// The reciprocal is rounded up; the shift makes the quotient exact for any numerator.
	localparam int RECIP_SH = NUM_W + $clog2(DEN);
	localparam int RECIP_W = NUM_W + 2;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SH) + 64'(DEN) - 64'd1) / 64'(DEN));

	// Captured request
	logic cmd_q;
	logic signed [15:0] ax_q, ay_q, az_q;

	// Squares and root
	logic [31:0] p1_q, p2_q;
	logic [59:0] nsh_q;
	logic [31:0] rem_q;
	logic [29:0] root_q;
	logic zero_q;
	logic [CNT_W-1:0] iter_q;

	// CORDIC
	logic signed [32:0] x_q, y_q;
	logic signed [24:0] z_q;
	logic signed [15:0] raw_q;

	// Divider
	logic [NUM_W-1:0] num_q;
	logic [15:0] quo_q;
	logic neg_q;

	// Block state and configuration
	logic signed [15:0] offset_q;
	logic signed [SUM_W-1:0] cal_sum_q;
	logic [CCNT_W-1:0] cal_cnt_q;
	logic [1:0] slope_q;
	logic en_q;
	logic [14:0] up_q, dn_q;

	// Output register
	logic out_valid_q;
	logic signed [16:0] pitch_q;
	logic [1:0] oslope_q;
	logic [14:0] mod_q;
	logic done_q;
	logic signed [15:0] ooff_q;

	logic signed [31:0] sq_x, sq_z;
	logic [31:0] sq_sum;
	logic [33:0] s_rem, s_trial;
	logic s_ge;
	logic signed [32:0] xs, ys;
	logic signed [24:0] at, zr, zq;
	logic signed [15:0] raw_d;
	logic signed [SUM_W-1:0] sum_new;
	logic [SUM_W-1:0] mag;
	logic [NUM_W+RECIP_W-1:0] prod;
	logic [15:0] qv;
	logic signed [15:0] off_new;
	logic signed [16:0] pitch_m;
	logic [1:0] slope_new;
	logic [14:0] mod_new;

	assign sample.ready = cmd.take;
	assign cfg.ready = 1'b1;

	assign sq_x = ax_q * ax_q;
	assign sq_z = az_q * az_q;
	assign sq_sum = p1_q + p2_q;

	assign s_rem = {rem_q, nsh_q[59:58]};
	assign s_trial = {2'b00, root_q, 2'b01};
	assign s_ge = s_rem >= s_trial;

	assign xs = x_q >>> iter_q;
	assign ys = y_q >>> iter_q;
	assign at = signed'({3'b000, atan_q16(iter_q)});

	// Q16 to Q8.8, ties toward plus infinity, then clamped
	always_comb begin
		zr = z_q + 25'sd128;
		zq = zr >>> 8;
		if (zero_q) begin
			raw_d = '0;
		end else if (zq > 25'sd23040) begin
			raw_d = 16'sd23040;
		end else if (zq < -25'sd23040) begin
			raw_d = -16'sd23040;
		end else begin
			raw_d = zq[15:0];
		end
	end

	assign sum_new = cal_sum_q + SUM_W'(raw_q);
	assign mag = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);

	assign prod = num_q * RECIP;

	assign qv = quo_q;
	assign off_new = neg_q ? -signed'(qv) : signed'(qv);

	assign pitch_m = 17'(raw_q) - 17'(offset_q);

	always_comb begin
		slope_new = slope_q;
		if (cmd_q == CMD_MEASURE && en_q) begin
			if (pitch_m > signed'({2'b00, up_q})) begin
				slope_new = SLOPE_UP;
			end else if (pitch_m < -signed'({2'b00, dn_q})) begin
				slope_new = SLOPE_DOWN;
			end else begin
				slope_new = SLOPE_LEVEL;
			end
		end
		if (!en_q) begin
			mod_new = MOD_ONE;
		end else if (slope_new == SLOPE_UP) begin
			mod_new = MOD_UP;
		end else if (slope_new == SLOPE_DOWN) begin
			mod_new = MOD_DOWN;
		end else begin
			mod_new = MOD_ONE;
		end
	end

	assign stat.in_valid = sample.valid;
	assign stat.sqrt_last = iter_q == CNT_W'(SQRT_STEPS - 1);
	assign stat.cordic_last = iter_q == CNT_W'(STEPS - 1);
	assign stat.cal_last = (cmd_q == CMD_CAL) && (cal_cnt_q == CCNT_W'(CAL_SAMPLES - 1));
	assign stat.out_free = !out_valid_q || result.ready;

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.take && sample.valid) begin
			cmd_q <= sample.cmd;
			ax_q <= sample.accel_x;
			ay_q <= sample.accel_y;
			az_q <= sample.accel_z;
		end
		if (cmd.mul_x) p1_q <= unsigned'(sq_x);
		if (cmd.mul_z) p2_q <= unsigned'(sq_z);
		if (cmd.sqrt_init) begin
			nsh_q <= {sq_sum, 28'b0};
			rem_q <= '0;
			root_q <= '0;
			zero_q <= (sq_sum == '0) && (ay_q == '0);
		end
		if (cmd.sqrt_step) begin
			rem_q <= s_ge ? 32'(s_rem - s_trial) : s_rem[31:0];
			root_q <= {root_q[28:0], s_ge};
			nsh_q <= {nsh_q[57:0], 2'b00};
		end
		if (cmd.cordic_init) begin
			x_q <= signed'({3'b000, root_q});
			y_q <= {{3{ay_q[15]}}, ay_q, 14'b0};
			z_q <= '0;
		end
		if (cmd.cordic_step) begin
			if (!y_q[32]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
		if (cmd.angle) raw_q <= raw_d;
		if (cmd.div_init) begin
			num_q <= (NUM_W'(mag) << 1) + NUM_W'(CAL_SAMPLES);
			neg_q <= sum_new[SUM_W-1];
		end
		if (cmd.div_step) quo_q <= prod[RECIP_SH +: 16];
		if (cmd.commit) begin
			pitch_q <= (cmd_q == CMD_MEASURE) ? pitch_m : 17'(raw_q);
			oslope_q <= slope_new;
			mod_q <= mod_new;
			done_q <= stat.cal_last;
			ooff_q <= stat.cal_last ? off_new : offset_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (cmd.sqrt_init || cmd.cordic_init) begin
			iter_q <= '0;
		end else if (cmd.sqrt_step || cmd.cordic_step) begin
			iter_q <= iter_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
			up_q <= 15'd1280;
			dn_q <= 15'd1280;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ENABLE: en_q <= cfg.data[0];
				REG_UP_LIMIT: up_q <= cfg.data;
				REG_DOWN_LIMIT: dn_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			cal_sum_q <= '0;
			cal_cnt_q <= '0;
			slope_q <= SLOPE_LEVEL;
			out_valid_q <= 1'b0;
		end else begin
			if (result.valid && result.ready) out_valid_q <= 1'b0;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				slope_q <= slope_new;
				if (cmd_q == CMD_MEASURE || stat.cal_last) begin
					cal_sum_q <= '0;
					cal_cnt_q <= '0;
				end else begin
					cal_sum_q <= sum_new;
					cal_cnt_q <= cal_cnt_q + 1'b1;
				end
				if (stat.cal_last) offset_q <= off_new;
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.pitch = pitch_q;
	assign result.slope = oslope_q;
	assign result.rate_modifier = mod_q;
	assign result.cal_done = done_q;
	assign result.offset_now = ooff_q;

endmodule

/* rtl/tilt_slope_classifier.sv */
// Tilt slope classifier: each request is one accelerometer sample and yields one result.
// An item passes from acceptance to the output register through the bit-serial square root
// and the one-step-per-cycle CORDIC loop, with at most 24 CORDIC steps used; the item that
// completes a calibration then also forms the rounded mean with a reciprocal multiply. One
// item is worked at a time, and the next is accepted while the previous result still waits
// in the output register, so a new request is taken only once the last one is committed.
// Configuration is always ready and is meant to be written only while no request is in flight.
module tilt_slope_classifier
	import tsc_pkg::*;
#(
	parameter int CAL_SAMPLES = 10,
	parameter int CORDIC_STEPS = 16
) (
	input logic       clk,
	input logic       arst_n,
	tsc_in_if.sink    sample,
	tsc_cfg_if.sink   cfg,
	tsc_out_if.source result
);

	tsc_cmd_t cmd;
	tsc_stat_t stat;

	tsc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.stat(stat),
		.cmd(cmd)
	);

	tsc_dp #(
		.CAL_SAMPLES(CAL_SAMPLES),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.sample(sample),
		.cfg(cfg),
		.result(result)
	);

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("request accepted while busy");

	a_slope_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.slope != 2'd3)
		else $error("bad slope code");

	a_mod_up: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.slope == SLOPE_UP |->
		result.rate_modifier == MOD_UP || result.rate_modifier == MOD_ONE)
		else $error("modifier does not match slope");

	a_cal_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.cal_done |-> result.rate_modifier != MOD_DOWN ||
		result.slope == SLOPE_DOWN)
		else $error("calibration changed modifier");

endmodule

/* tb/sv/tsc_tb_if.sv */
`timescale 1ns / 100ps

// Channel interfaces are defined with the RTL; this file holds the testbench's
// shared record of one request and one result.
package tsc_tb_pkg;

	typedef struct {
		logic cmd;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
	} tilt_sample_t;

	typedef struct {
		logic signed [16:0] pitch;
		logic [1:0] slope;
		logic [14:0] rate_modifier;
		logic cal_done;
		logic signed [15:0] offset_now;
	} tilt_result_t;

endpackage

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import tsc_pkg::*;
	import tsc_tb_pkg::*;

	localparam int CAL_N = 10;
	localparam int STEPS = 16;
	localparam int N_RANDOM = 1500;
	localparam int HOLD_CYCLES = 400;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// Bit-exact model of the classifier with its own copy of state and registers.
	class tilt_scoreboard;
		logic enable;
		int up_lim;
		int down_lim;
		int offset;
		int cal_acc;
		int cal_cnt;
		logic [1:0] slope_state;
		tilt_result_t pending[$];
		int errors;
		int checked;
		int cal_completions;

		function void clear_state();
			enable = 1'b1;
			up_lim = 1280;
			down_lim = 1280;
			offset = 0;
			cal_acc = 0;
			cal_cnt = 0;
			slope_state = SLOPE_LEVEL;
			pending.delete();
			errors = 0;
			checked = 0;
			cal_completions = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [14:0] val);
			if (idx == REG_ENABLE) enable = val[0];
			else if (idx == REG_UP_LIMIT) up_lim = int'(val);
			else if (idx == REG_DOWN_LIMIT) down_lim = int'(val);
		endfunction

		function longint floor_shift(longint v, int s);
			return v >>> s;
		endfunction

		function longint root_floor(longint unsigned n);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function int tilt_degrees(int ax, int ay, int az);
			longint unsigned sq;
			longint x, y, z, xs, ys, q;
			sq = longint'(ax) * ax + longint'(az) * az;
			if (sq == 0 && ay == 0) return 0;
			x = root_floor(sq << 28);
			y = longint'(ay) * 16384;
			z = 0;
			for (int i = 0; i < STEPS; i++) begin
				xs = floor_shift(x, i);
				ys = floor_shift(y, i);
				if (y >= 0) begin
					x += ys; y -= xs; z += atan_q16(i[4:0]);
				end else begin
					x -= ys; y += xs; z -= atan_q16(i[4:0]);
				end
			end
			q = floor_shift(z + 128, 8);
			if (q > ANGLE_MAX) q = ANGLE_MAX;
			if (q < -ANGLE_MAX) q = -ANGLE_MAX;
			return int'(q);
		endfunction

		function void note_sample(tilt_sample_t s);
			tilt_result_t r;
			int raw, p;
			longint mag, qv;
			raw = tilt_degrees(s.ax, s.ay, s.az);
			r.cal_done = 1'b0;
			if (s.cmd == CMD_MEASURE) begin
				cal_acc = 0;
				cal_cnt = 0;
				p = raw - offset;
				if (enable) begin
					if (p > up_lim) slope_state = SLOPE_UP;
					else if (p < -down_lim) slope_state = SLOPE_DOWN;
					else slope_state = SLOPE_LEVEL;
				end
			end else begin
				p = raw;
				cal_acc += raw;
				cal_cnt++;
				if (cal_cnt >= CAL_N) begin
					mag = longint'(cal_acc < 0 ? -cal_acc : cal_acc);
					qv = (2 * mag + CAL_N) / (2 * CAL_N);
					offset = int'(cal_acc < 0 ? -qv : qv);
					cal_acc = 0;
					cal_cnt = 0;
					r.cal_done = 1'b1;
					cal_completions++;
				end
			end
			if (!enable) r.rate_modifier = MOD_ONE;
			else if (slope_state == SLOPE_UP) r.rate_modifier = MOD_UP;
			else if (slope_state == SLOPE_DOWN) r.rate_modifier = MOD_DOWN;
			else r.rate_modifier = MOD_ONE;
			r.pitch = 17'(p);
			r.slope = slope_state;
			r.offset_now = 16'(offset);
			pending.push_back(r);
		endfunction

		function void check_result(tilt_result_t a);
			tilt_result_t e;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result pitch=%0d", $time, a.pitch);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.pitch !== e.pitch || a.slope !== e.slope ||
				a.rate_modifier !== e.rate_modifier || a.cal_done !== e.cal_done ||
				a.offset_now !== e.offset_now) begin
				$display("%0t: mismatch expected pitch=%0d slope=%0d mod=%0d done=%0d off=%0d",
					$time, e.pitch, e.slope, e.rate_modifier, e.cal_done, e.offset_now);
				$display("%0t:            actual pitch=%0d slope=%0d mod=%0d done=%0d off=%0d",
					$time, a.pitch, a.slope, a.rate_modifier, a.cal_done, a.offset_now);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int send_idle_pct;
	int recv_idle_pct;
	logic hold_req;
	logic recv_hold;
	int sent;
	tilt_scoreboard sb;

	tsc_in_if sample_ch();
	tsc_out_if result_ch();
	tsc_cfg_if cfg_ch();

	tilt_slope_classifier #(.CAL_SAMPLES(CAL_N), .CORDIC_STEPS(STEPS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch.sink),
		.cfg(cfg_ch.sink),
		.result(result_ch.source)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Result side: random stalls plus one long hold-off.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready)
				sb.check_result('{result_ch.pitch, result_ch.slope, result_ch.rate_modifier,
					result_ch.cal_done, result_ch.offset_now});
			if (recv_hold) begin
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end else begin
			result_ch.ready <= 1'b0;
		end
	end

	// The long hold-off is counted here while the sender keeps offering requests.
	initial begin
		recv_hold = 1'b0;
		wait (hold_req === 1'b1);
		@(posedge clk);
		recv_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		recv_hold <= 1'b0;
	end

	task automatic send_sample(logic cmd, logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.cmd <= cmd;
		sample_ch.accel_x <= ax;
		sample_ch.accel_y <= ay;
		sample_ch.accel_z <= az;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		sb.note_sample('{cmd, ax, ay, az});
		sent++;
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [14:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		sb.write_reg(idx, val);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_axis();
		case ($urandom_range(4))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($signed($urandom_range(64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_block(int n);
		int k;
		k = 0;
		while (k < n) begin
			// Mostly single measurements, with full calibration runs and broken runs mixed in.
			if ($urandom_range(9) < 2) begin
				for (int j = 0; j < CAL_N; j++)
					send_sample(CMD_CAL, 16'($urandom_range(2000) - 1000),
						16'($signed($urandom_range(8000)) - 4000), 16'd16000);
				k += CAL_N;
			end else if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(CAL_N - 1, 1))
					send_sample(CMD_CAL, rand_axis(), rand_axis(), rand_axis());
				send_sample(CMD_MEASURE, rand_axis(), rand_axis(), rand_axis());
				k += 5;
			end else begin
				send_sample(CMD_MEASURE, rand_axis(), rand_axis(), rand_axis());
				k++;
			end
		end
	endtask

	initial begin
		sb = new();
		sb.clear_state();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b0;
		sent = 0;
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.cmd = CMD_MEASURE;
		sample_ch.accel_x = '0;
		sample_ch.accel_y = '0;
		sample_ch.accel_z = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_ENABLE;
		cfg_ch.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: axis extremes, zero vector, both commands, full and broken calibration.
		send_sample(CMD_MEASURE, 16'd0, 16'd0, 16'd0);
		send_sample(CMD_MEASURE, 16'd0, 16'h7FFF, 16'd0);
		send_sample(CMD_MEASURE, 16'd0, 16'h8000, 16'd0);
		send_sample(CMD_MEASURE, 16'h8000, 16'h8000, 16'h8000);
		send_sample(CMD_MEASURE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_sample(CMD_MEASURE, 16'd16384, 16'd0, 16'h8000);
		send_sample(CMD_MEASURE, 16'd0, 16'd5000, 16'd16000);
		send_sample(CMD_MEASURE, 16'd0, -16'sd5000, 16'd16000);
		repeat (3) send_sample(CMD_CAL, 16'd0, 16'd3000, 16'd16000);
		send_sample(CMD_MEASURE, 16'd0, 16'd1, 16'd1);
		repeat (CAL_N) send_sample(CMD_CAL, 16'd0, 16'd3000, 16'd16000);
		send_sample(CMD_MEASURE, 16'd0, 16'd3000, 16'd16000);
		send_sample(CMD_MEASURE, 16'd0, 16'h8000, 16'd1);
		drain();
		write_cfg(REG_ENABLE, 15'd0);
		write_cfg(REG_UP_LIMIT, 15'd0);
		write_cfg(REG_DOWN_LIMIT, 15'd0);
		write_cfg(REG_UNUSED, 15'h7FFF);
		send_sample(CMD_MEASURE, 16'd0, 16'd9000, 16'd100);
		send_sample(CMD_MEASURE, 16'd0, -16'sd9000, 16'd100);
		drain();
		write_cfg(REG_ENABLE, 15'd1);
		send_sample(CMD_MEASURE, 16'd0, 16'd0, 16'd100);
		send_sample(CMD_MEASURE, 16'd0, 16'd5, 16'd100);

		send_idle_pct = 10;
		recv_idle_pct = 70;
		random_block(N_RANDOM / 5);
		drain();
		write_cfg(REG_UP_LIMIT, 15'd23040);
		write_cfg(REG_DOWN_LIMIT, 15'd23040);
		send_idle_pct = 70;
		recv_idle_pct = 10;
		random_block(N_RANDOM / 5);
		drain();
		write_cfg(REG_UP_LIMIT, 15'h7FFF);
		write_cfg(REG_DOWN_LIMIT, 15'd300);
		hold_req = 1'b1;
		random_block(N_RANDOM / 5);
		drain();
		write_cfg(REG_ENABLE, 15'd0);
		write_cfg(REG_UP_LIMIT, 15'd1280);
		write_cfg(REG_DOWN_LIMIT, 15'd1280);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_block(N_RANDOM / 5);
		drain();
		write_cfg(REG_ENABLE, 15'd1);
		random_block(N_RANDOM / 5);
		drain();
		$display("Run covered %0d requests and %0d results, %0d completed calibrations,",
			sent, sb.checked, sb.cal_completions);
		$display("across five register settings with stalls on both sides.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tilt_slope_classifier verification clean");
		else
			$display("tilt_slope_classifier verification failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("tilt_slope_classifier verification failed");
		$finish;
	end

endmodule

/* files.f */
rtl/tsc_pkg.sv
rtl/tsc_if.sv
rtl/tsc_ctrl.sv
rtl/tsc_dp.sv
rtl/tilt_slope_classifier.sv
tb/sv/tsc_tb_if.sv
tb/sv/testbench.sv
